// ===== rtl/core/hau_pkg.sv =====
// Shared types and constants for the three-track hit assigner.
// No dependencies.
`default_nettype none
package hau_pkg;
    localparam int CoordW = 16;
    localparam int SqW    = 31;
    localparam int R2W    = 32;
    localparam int CosW   = 33;
    localparam int CntW   = 5;
    localparam int DivSteps  = 31;
    localparam int SqrtSteps = 16;

    typedef logic [2:0][CoordW-1:0] vec3_t;
    typedef logic [2:0][2:0][CosW-1:0] cosm_t;
    typedef logic [2:0][1:0] trk_map_t;

    typedef enum logic [2:0] {
        LN_IDLE,
        LN_SUM,
        LN_DIV,
        LN_SQRT,
        LN_DONE
    } lane_state_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_NORM,
        ST_COS,
        ST_PAIR,
        ST_WRITE
    } state_t;

    typedef struct packed {
        logic clear;
        logic step;
    } merge_ctrl_t;
endpackage
`default_nettype wire

// ===== rtl/core/hau_if.sv =====
// Request and result channel interfaces.
// No dependencies.
`default_nettype none
interface hau_in_if;
    logic valid;
    logic ready;
    logic start_req;
    logic three_hits;
    logic signed [15:0] hit_a_x;
    logic signed [15:0] hit_a_y;
    logic signed [15:0] hit_a_z;
    logic signed [15:0] hit_b_x;
    logic signed [15:0] hit_b_y;
    logic signed [15:0] hit_b_z;
    logic signed [15:0] hit_c_x;
    logic signed [15:0] hit_c_y;
    logic signed [15:0] hit_c_z;
    modport source (output valid, start_req, three_hits, hit_a_x, hit_a_y, hit_a_z,
                    hit_b_x, hit_b_y, hit_b_z, hit_c_x, hit_c_y, hit_c_z, input ready);
    modport sink (input valid, start_req, three_hits, hit_a_x, hit_a_y, hit_a_z,
                  hit_b_x, hit_b_y, hit_b_z, hit_c_x, hit_c_y, hit_c_z, output ready);
endinterface

interface hau_out_if;
    logic valid;
    logic ready;
    logic [1:0] track_of_hit_a;
    logic [1:0] track_of_hit_b;
    logic [1:0] track_of_hit_c;
    logic seeded;
    modport source (output valid, track_of_hit_a, track_of_hit_b, track_of_hit_c,
                    seeded, input ready);
    modport sink (input valid, track_of_hit_a, track_of_hit_b, track_of_hit_c,
                  seeded, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/hau_lane.sv =====
// One hit lane: unit direction by restoring divide and digit square root,
// then the cosine of that direction against one selected track. Uses hau_pkg.
`default_nettype none
module hau_lane (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    input  wire hau_pkg::vec3_t pos,
    input  wire hau_pkg::vec3_t trk,
    output logic               done,
    output hau_pkg::vec3_t     unit,
    output logic [hau_pkg::CosW-1:0] cosv
);
    hau_pkg::lane_state_t state_reg, state_next;
    logic [hau_pkg::CntW-1:0] cnt_reg, cnt_next;
    logic [2:0] neg_reg;
    logic [2:0][hau_pkg::SqW-1:0] a2_reg;
    logic [hau_pkg::R2W-1:0] r2_reg;
    logic [2:0][hau_pkg::R2W-1:0] rem_reg;
    logic [2:0][hau_pkg::SqW-1:0] nsh_reg;
    logic [2:0][hau_pkg::SqW-1:0] q_reg;
    logic [2:0][31:0] qs_reg;
    logic [2:0][17:0] srem_reg;
    logic [2:0][15:0] root_reg;
    hau_pkg::vec3_t unit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= hau_pkg::LN_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        unique case (state_reg)
            hau_pkg::LN_IDLE, hau_pkg::LN_DONE:
            begin
                if (start)
                begin
                    state_next = hau_pkg::LN_SUM;
                end
            end
            hau_pkg::LN_SUM:
            begin
                state_next = hau_pkg::LN_DIV;
                cnt_next   = '0;
            end
            hau_pkg::LN_DIV:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == hau_pkg::CntW'(hau_pkg::DivSteps - 1))
                begin
                    state_next = hau_pkg::LN_SQRT;
                    cnt_next   = '0;
                end
            end
            hau_pkg::LN_SQRT:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == hau_pkg::CntW'(hau_pkg::SqrtSteps + 1))
                begin
                    state_next = hau_pkg::LN_DONE;
                end
            end
            default:
            begin
                state_next = hau_pkg::LN_IDLE;
            end
        endcase
    end

    logic [2:0][15:0] mag;
    logic [2:0][hau_pkg::R2W:0] dtrial;
    logic [2:0][19:0] strial;
    logic [2:0][19:0] ssub;
    logic [2:0][15:0] sat;

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            mag[k] = pos[k][15] ? 16'(-pos[k]) : pos[k];
            dtrial[k] = {rem_reg[k], nsh_reg[k][hau_pkg::SqW-1]};
            strial[k] = {srem_reg[k], qs_reg[k][31:30]};
            ssub[k] = {2'b00, root_reg[k], 2'b01};
            sat[k] = (root_reg[k] > 16'd32767) ? 16'd32767 : root_reg[k];
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < 3; k++)
        begin
            if ((state_reg == hau_pkg::LN_IDLE || state_reg == hau_pkg::LN_DONE) && start)
            begin
                neg_reg[k] <= pos[k][15];
                a2_reg[k]  <= hau_pkg::SqW'({16'd0, mag[k]} * {16'd0, mag[k]});
            end
            if (state_reg == hau_pkg::LN_SUM)
            begin
                rem_reg[k] <= hau_pkg::R2W'(a2_reg[k] >> 1);
                nsh_reg[k] <= {a2_reg[k][0], 30'd0};
                q_reg[k]   <= '0;
            end
            if (state_reg == hau_pkg::LN_DIV)
            begin
                nsh_reg[k] <= nsh_reg[k] << 1;
                if (dtrial[k] >= {1'b0, r2_reg})
                begin
                    rem_reg[k] <= hau_pkg::R2W'(dtrial[k] - {1'b0, r2_reg});
                    q_reg[k]   <= {q_reg[k][hau_pkg::SqW-2:0], 1'b1};
                end
                else
                begin
                    rem_reg[k] <= hau_pkg::R2W'(dtrial[k]);
                    q_reg[k]   <= {q_reg[k][hau_pkg::SqW-2:0], 1'b0};
                end
                if (cnt_reg == hau_pkg::CntW'(hau_pkg::DivSteps - 1))
                begin
                    srem_reg[k] <= '0;
                    root_reg[k] <= '0;
                end
            end
            if (state_reg == hau_pkg::LN_SQRT)
            begin
                if (cnt_reg == '0)
                begin
                    qs_reg[k] <= {1'b0, q_reg[k]};
                end
                else if (cnt_reg == hau_pkg::CntW'(hau_pkg::SqrtSteps + 1))
                begin
                    unit_reg[k] <= (r2_reg != '0) ?
                                   (neg_reg[k] ? 16'(-sat[k]) : sat[k]) : 16'd0;
                end
                if (cnt_reg != hau_pkg::CntW'(hau_pkg::SqrtSteps + 1))
                begin
                    if (cnt_reg != '0)
                    begin
                        qs_reg[k] <= qs_reg[k] << 2;
                        if (strial[k] >= ssub[k])
                        begin
                            srem_reg[k] <= 18'(strial[k] - ssub[k]);
                            root_reg[k] <= {root_reg[k][14:0], 1'b1};
                        end
                        else
                        begin
                            srem_reg[k] <= 18'(strial[k]);
                            root_reg[k] <= {root_reg[k][14:0], 1'b0};
                        end
                    end
                end
            end
        end
        if (state_reg == hau_pkg::LN_SUM)
        begin
            r2_reg <= hau_pkg::R2W'({1'b0, a2_reg[0]} + {1'b0, a2_reg[1]})
                      + hau_pkg::R2W'(a2_reg[2]);
        end
    end

    // SQRT loads the radicand at count 0 and writes the unit at the last count, so the counter runs to SqrtSteps + 1
    logic signed [31:0] p0, p1, p2;
    assign p0 = $signed(trk[0]) * $signed(unit_reg[0]);
    assign p1 = $signed(trk[1]) * $signed(unit_reg[1]);
    assign p2 = $signed(trk[2]) * $signed(unit_reg[2]);
    assign cosv = hau_pkg::CosW'($signed({p0[31], p0}) + $signed({p1[31], p1})
                                  + $signed({p2[31], p2}));
    assign unit = unit_reg;
    assign done = (state_reg == hau_pkg::LN_DONE);

    a_sum_after_start: assert property (@(posedge clk) disable iff (!rst_n)
        (start && (state_reg == hau_pkg::LN_IDLE || state_reg == hau_pkg::LN_DONE))
        |=> state_reg == hau_pkg::LN_SUM)
        else $error("lane did not begin");
    a_div_to_sqrt: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == hau_pkg::LN_DIV && cnt_reg == hau_pkg::CntW'(hau_pkg::DivSteps - 1))
        |=> state_reg == hau_pkg::LN_SQRT && cnt_reg == '0)
        else $error("divide length wrong");
    a_rem_below: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == hau_pkg::LN_DIV) |-> rem_reg[0] < r2_reg || r2_reg == '0)
        else $error("divide remainder out of range");
endmodule
`default_nettype wire

// ===== rtl/core/hau_merge.sv =====
// Greedy pairing of tracks and hits, one pair per step, largest cosine first.
// Uses hau_pkg.
`default_nettype none
module hau_merge (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire hau_pkg::merge_ctrl_t ctrl,
    input  wire hau_pkg::cosm_t      cosm,
    output hau_pkg::trk_map_t        hit_track
);
    logic [2:0] tu_reg, hu_reg;
    hau_pkg::trk_map_t map_reg;
    logic found;
    logic [1:0] bi, bj;
    logic signed [hau_pkg::CosW-1:0] best;

    always_comb
    begin
        found = 1'b0;
        bi = '0;
        bj = '0;
        best = '0;
        for (int i = 0; i < 3; i++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                if (!tu_reg[i] && !hu_reg[j])
                begin
                    if (!found || $signed(cosm[i][j]) > best)
                    begin
                        found = 1'b1;
                        best = $signed(cosm[i][j]);
                        bi = 2'(i);
                        bj = 2'(j);
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tu_reg  <= '0;
            hu_reg  <= '0;
            map_reg <= '0;
        end
        else if (ctrl.clear)
        begin
            tu_reg  <= '0;
            hu_reg  <= '0;
            map_reg <= '0;
        end
        else if (ctrl.step && found)
        begin
            tu_reg[bi]  <= 1'b1;
            hu_reg[bj]  <= 1'b1;
            map_reg[bj] <= bi;
        end
    end

    assign hit_track = map_reg;

    a_masks_match: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(tu_reg) == $countones(hu_reg))
        else $error("pair masks out of step");
    a_step_finds: assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl.step && !ctrl.clear && tu_reg != 3'b111) |=> $countones(tu_reg) ==
        $countones($past(tu_reg)) + 1)
        else $error("step made no pair");
    a_clear: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.clear |=> tu_reg == '0 && hu_reg == '0)
        else $error("clear failed");
endmodule
`default_nettype wire

// ===== rtl/core/three_track_hit_assigner.sv =====
// Top level: three normalize lanes, cosine sweep, greedy merge, track store.
// Depends on hau_pkg, hau_if, hau_lane, hau_merge.
//   channel  | role   | payload
//   layer    | sink   | start_req, three_hits, nine hit coordinates
//   result   | source | track_of_hit_a/b/c, seeded
// A request with three hits goes through normalize (the 31-step divide and 16-step
// root in each lane), then cosine, pairing and write; a seeding request goes from
// normalize straight to write. The next request is taken after WRITE, back in IDLE.
// A request without three hits is taken in IDLE and gives no result.
// Reset clears the tracks; a stalled result holds the next finished request in WRITE.
`default_nettype none
module three_track_hit_assigner (
    input  wire logic  clk,
    input  wire logic  rst_n,
    hau_in_if.sink     layer,
    hau_out_if.source  result
);
    hau_pkg::state_t state_reg, state_next;
    logic [1:0] cnt_reg, cnt_next;
    logic started_reg, seed_reg;
    hau_pkg::vec3_t dir_reg [3];
    hau_pkg::cosm_t cos_reg;
    logic out_valid_reg;
    hau_pkg::trk_map_t out_map_reg;
    logic out_seed_reg;

    hau_pkg::vec3_t pos [3];
    hau_pkg::vec3_t unit [3];
    logic [hau_pkg::CosW-1:0] cosv [3];
    logic [2:0] done;
    hau_pkg::trk_map_t hit_track;
    hau_pkg::merge_ctrl_t mctrl;
    logic accept, go, out_free;

    assign pos[0] = {layer.hit_a_z, layer.hit_a_y, layer.hit_a_x};
    assign pos[1] = {layer.hit_b_z, layer.hit_b_y, layer.hit_b_x};
    assign pos[2] = {layer.hit_c_z, layer.hit_c_y, layer.hit_c_x};

    assign layer.ready = (state_reg == hau_pkg::ST_IDLE);
    assign accept = layer.valid && layer.ready;
    assign go = accept && layer.three_hits;
    assign out_free = !out_valid_reg || result.ready;

    for (genvar j = 0; j < 3; j++)
    begin : g_lane
        hau_lane u_lane (
            .clk   (clk),
            .rst_n (rst_n),
            .start (go),
            .pos   (pos[j]),
            .trk   (dir_reg[cnt_reg]),
            .done  (done[j]),
            .unit  (unit[j]),
            .cosv  (cosv[j])
        );
    end

    assign mctrl.clear = (state_reg == hau_pkg::ST_NORM);
    assign mctrl.step  = (state_reg == hau_pkg::ST_PAIR);

    hau_merge u_merge (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (mctrl),
        .cosm      (cos_reg),
        .hit_track (hit_track)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= hau_pkg::ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        unique case (state_reg)
            hau_pkg::ST_IDLE:
            begin
                if (go)
                begin
                    state_next = hau_pkg::ST_NORM;
                end
            end
            hau_pkg::ST_NORM:
            begin
                cnt_next = '0;
                if (done == 3'b111)
                begin
                    state_next = seed_reg ? hau_pkg::ST_WRITE : hau_pkg::ST_COS;
                end
            end
            hau_pkg::ST_COS:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == 2'd2)
                begin
                    state_next = hau_pkg::ST_PAIR;
                    cnt_next   = '0;
                end
            end
            hau_pkg::ST_PAIR:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == 2'd2)
                begin
                    state_next = hau_pkg::ST_WRITE;
                    cnt_next   = '0;
                end
            end
            hau_pkg::ST_WRITE:
            begin
                if (out_free)
                begin
                    state_next = hau_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = hau_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            started_reg   <= 1'b0;
            seed_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < 3; i++)
            begin
                dir_reg[i] <= '0;
            end
        end
        else
        begin
            if (accept)
            begin
                if (layer.start_req)
                begin
                    started_reg <= 1'b0;
                end
                seed_reg <= layer.start_req || !started_reg;
            end
            if (state_reg == hau_pkg::ST_WRITE && out_free)
            begin
                out_valid_reg <= 1'b1;
                started_reg   <= 1'b1;
                for (int j = 0; j < 3; j++)
                begin
                    if (seed_reg)
                    begin
                        dir_reg[j] <= unit[j];
                    end
                    else
                    begin
                        dir_reg[hit_track[j]] <= unit[j];
                    end
                end
            end
            else if (out_valid_reg && result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == hau_pkg::ST_COS)
        begin
            for (int j = 0; j < 3; j++)
            begin
                cos_reg[cnt_reg][j] <= cosv[j];
            end
        end
        if (state_reg == hau_pkg::ST_WRITE && out_free)
        begin
            out_seed_reg <= seed_reg;
            out_map_reg  <= seed_reg ? {2'd2, 2'd1, 2'd0} : hit_track;
        end
    end

    assign result.valid          = out_valid_reg;
    assign result.track_of_hit_a = out_map_reg[0];
    assign result.track_of_hit_b = out_map_reg[1];
    assign result.track_of_hit_c = out_map_reg[2];
    assign result.seeded         = out_seed_reg;

    a_seed_map: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.seeded) |-> result.track_of_hit_a == 2'd0 &&
        result.track_of_hit_b == 2'd1 && result.track_of_hit_c == 2'd2)
        else $error("seeded map wrong");
    a_distinct: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> result.track_of_hit_a != result.track_of_hit_b &&
        result.track_of_hit_b != result.track_of_hit_c &&
        result.track_of_hit_a != result.track_of_hit_c)
        else $error("tracks assigned twice");
    a_skip_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !layer.three_hits) |=> state_reg == hau_pkg::ST_IDLE)
        else $error("skipped layer started work");
endmodule
`default_nettype wire

// ===== tb/sv/tb_hau_if.sv =====
`timescale 1ns / 1ps
// Testbench copy note: the channel interfaces come from rtl/core/hau_if.sv.
// This file holds only the shared timescale for the testbench build; no declarations.

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
// Testbench for three_track_hit_assigner: drives layer requests, predicts track
// assignments with a bit-exact model of normalization and greedy pairing.
// Depends on hau_pkg, hau_if and the RTL top level.
module tb;
    typedef struct packed {
        logic [1:0] trk_a;
        logic [1:0] trk_b;
        logic [1:0] trk_c;
        logic       seeded;
    } assign_t;

    typedef logic signed [15:0] coord_t;

    logic clk;
    logic rst_n;
    hau_in_if  layer ();
    hau_out_if result ();

    three_track_hit_assigner u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .layer  (layer.sink),
        .result (result.source)
    );

    assign_t       expected_assignments[$];
    logic signed [31:0] trk_dir[3][3];
    logic          tracks_live;
    int            n_mismatch;
    int            idle_cycles;
    bit            src_idle_on;
    bit            snk_idle_on;
    int            hold_off;

    initial clk = 1'b0;
    always #5 clk = ~clk;

    function automatic logic [63:0] root64(input logic [63:0] v);
        logic [63:0] res;
        logic [63:0] b;
        res = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0)
        begin
            if (v >= res + b)
            begin
                v = v - (res + b);
                res = (res >> 1) + b;
            end
            else
                res = res >> 1;
            b = b >> 2;
        end
        return res;
    endfunction

    task automatic unit_dir(input coord_t p[3], output logic signed [31:0] u[3]);
        logic [63:0] mag[3];
        logic [63:0] r2;
        logic [63:0] s;
        r2 = 0;
        for (int k = 0; k < 3; k++)
        begin
            mag[k] = p[k] < 0 ? 64'(-$signed(32'(p[k]))) : 64'(p[k]);
            r2 += mag[k] * mag[k];
        end
        for (int k = 0; k < 3; k++)
        begin
            if (r2 == 0)
                u[k] = 0;
            else
            begin
                s = root64(((mag[k] * mag[k]) << 30) / r2);
                if (s > 32767) s = 32767;
                u[k] = p[k] < 0 ? -$signed(32'(s)) : $signed(32'(s));
            end
        end
    endtask

    task automatic assign_hits(input logic strt, input logic three, input coord_t h[9]);
        coord_t p[3];
        logic signed [31:0] u[3][3];
        logic signed [63:0] cs[3][3];
        logic signed [63:0] best;
        int hit_trk[3];
        bit tu[3];
        bit hu[3];
        int bi;
        int bj;
        assign_t r;
        if (strt) tracks_live = 1'b0;
        if (!three) return;
        for (int j = 0; j < 3; j++)
        begin
            for (int k = 0; k < 3; k++) p[k] = h[3*j+k];
            unit_dir(p, u[j]);
        end
        if (!tracks_live)
        begin
            for (int i = 0; i < 3; i++)
                for (int k = 0; k < 3; k++) trk_dir[i][k] = u[i][k];
            tracks_live = 1'b1;
            r = '{2'd0, 2'd1, 2'd2, 1'b1};
            expected_assignments = {expected_assignments, r};
            return;
        end
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
            begin
                cs[i][j] = 0;
                for (int k = 0; k < 3; k++)
                    cs[i][j] += 64'(trk_dir[i][k]) * 64'(u[j][k]);
            end
        for (int j = 0; j < 3; j++)
        begin
            hit_trk[j] = 0;
            tu[j] = 0;
            hu[j] = 0;
        end
        for (int rnd = 0; rnd < 3; rnd++)
        begin
            bi = -1;
            bj = -1;
            best = 0;
            for (int i = 0; i < 3; i++)
                for (int j = 0; j < 3; j++)
                    if (!tu[i] && !hu[j] && (bi < 0 || cs[i][j] > best))
                    begin
                        best = cs[i][j];
                        bi = i;
                        bj = j;
                    end
            tu[bi] = 1;
            hu[bj] = 1;
            hit_trk[bj] = bi;
        end
        for (int j = 0; j < 3; j++)
            for (int k = 0; k < 3; k++) trk_dir[hit_trk[j]][k] = u[j][k];
        r = '{hit_trk[0][1:0], hit_trk[1][1:0], hit_trk[2][1:0], 1'b0};
        expected_assignments = {expected_assignments, r};
    endtask

    // one request; waits for acceptance, valid stays up until the next request or a pause
    task automatic send_layer(input logic strt, input logic three, input coord_t h[9]);
        int gap;
        if (src_idle_on && $urandom_range(0, 5) == 0)
        begin
            gap = $urandom_range(1, 14);
            layer.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        layer.valid      <= 1'b1;
        layer.start_req  <= strt;
        layer.three_hits <= three;
        layer.hit_a_x <= h[0]; layer.hit_a_y <= h[1]; layer.hit_a_z <= h[2];
        layer.hit_b_x <= h[3]; layer.hit_b_y <= h[4]; layer.hit_b_z <= h[5];
        layer.hit_c_x <= h[6]; layer.hit_c_y <= h[7]; layer.hit_c_z <= h[8];
        @(negedge clk);
        while (!layer.ready) @(negedge clk);
        @(posedge clk);
        assign_hits(strt, three, h);
    endtask

    function automatic coord_t rand_coord();
        case ($urandom_range(0, 5))
            0: return coord_t'($urandom_range(0, 65535));
            1: return coord_t'(16'sh8000);
            2: return coord_t'(16'sh7fff);
            3: return coord_t'(0);
            default: return coord_t'($signed($urandom_range(0, 4000)) - 2000);
        endcase
    endfunction

    task automatic send_random(input int n, input int start_pct);
        coord_t h[9];
        logic three;
        for (int i = 0; i < n; i++)
        begin
            three = $urandom_range(0, 9) != 0;
            for (int k = 0; k < 9; k++) h[k] = rand_coord();
            send_layer($urandom_range(0, 99) < start_pct, three, h);
        end
    endtask

    task automatic drain();
        layer.valid <= 1'b0;
        while (expected_assignments.size() != 0) @(posedge clk);
        repeat (80) @(posedge clk);
    endtask

    task automatic test_directed();
        coord_t h[9];
        h = '{100, 0, 0, 0, 100, 0, 0, 0, 100};
        send_layer(1'b1, 1'b1, h);
        h = '{0, 0, 90, 80, 0, 0, 0, 70, 0};
        send_layer(1'b0, 1'b1, h);
        h = '{0, 0, 0, 0, 0, 0, 0, 0, 0};
        send_layer(1'b0, 1'b1, h);
        h = '{-32768, -32768, -32768, 32767, 32767, 32767, -32768, 0, 0};
        send_layer(1'b0, 1'b1, h);
        send_layer(1'b0, 1'b0, h);
        h = '{-32768, 0, 0, 32767, 0, 0, 0, -32768, 0};
        send_layer(1'b1, 1'b0, h);
        send_layer(1'b0, 1'b1, h);
        h = '{5, 5, 5, 5, 5, 5, 5, 5, 5};
        send_layer(1'b0, 1'b1, h);
        send_layer(1'b0, 1'b1, h);
        h = '{0, 0, 1, 0, 0, -1, 0, 1, 0};
        send_layer(1'b1, 1'b1, h);
        h = '{0, 1, 0, 0, 0, 1, 0, 0, -1};
        send_layer(1'b0, 1'b1, h);
        h = '{32767, 32767, 0, -1, -1, -1, 1, 1, 1};
        send_layer(1'b0, 1'b1, h);
    endtask

    task automatic test_backpressure();
        hold_off = 300;
        send_random(20, 10);
        layer.valid <= 1'b0;
        while (hold_off != 0) @(posedge clk);
        while (expected_assignments.size() != 0) @(posedge clk);
        send_random(10, 10);
    endtask

    // track continuity: small drifts of seeded directions
    task automatic test_tracks();
        coord_t h[9];
        coord_t base[9];
        coord_t t;
        for (int e = 0; e < 60; e++)
        begin
            for (int k = 0; k < 9; k++) base[k] = rand_coord();
            for (int l = 0; l < 12; l++)
            begin
                for (int k = 0; k < 9; k++)
                    h[k] = base[k] + coord_t'($signed($urandom_range(0, 60)) - 30);
                for (int s = 0; s < 2; s++)
                    if ($urandom_range(0, 1))
                    begin
                        t = h[3*s]; h[3*s] = h[3*s+3]; h[3*s+3] = t;
                        t = h[3*s+1]; h[3*s+1] = h[3*s+4]; h[3*s+4] = t;
                        t = h[3*s+2]; h[3*s+2] = h[3*s+5]; h[3*s+5] = t;
                    end
                send_layer(l == 0, $urandom_range(0, 11) != 0, h);
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result.ready <= 1'b0;
        else if (hold_off != 0)
        begin
            hold_off <= hold_off - 1;
            result.ready <= 1'b0;
        end
        else if (snk_idle_on && $urandom_range(0, 7) == 0)
        begin
            hold_off <= $urandom_range(1, 14);
            result.ready <= 1'b0;
        end
        else
            result.ready <= 1'b1;
    end

    always @(posedge clk)
    begin
        assign_t got;
        assign_t want;
        if (rst_n && result.valid && result.ready)
        begin
            got = '{result.track_of_hit_a, result.track_of_hit_b,
                    result.track_of_hit_c, result.seeded};
            if (expected_assignments.size() == 0)
            begin
                n_mismatch++;
                if (n_mismatch <= 10) $display("unexpected result %p", got);
            end
            else
            begin
                want = expected_assignments.pop_front();
                if (got !== want)
                begin
                    n_mismatch++;
                    if (n_mismatch <= 10) $display("mismatch exp %p got %p", want, got);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((layer.valid && layer.ready) || (result.valid && result.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 20000)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial
    begin
        n_mismatch  = 0;
        idle_cycles = 0;
        hold_off    = 0;
        tracks_live = 1'b0;
        src_idle_on = 1'b1;
        snk_idle_on = 1'b1;
        for (int i = 0; i < 3; i++)
            for (int k = 0; k < 3; k++) trk_dir[i][k] = 0;
        rst_n = 1'b0;
        layer.valid = 1'b0;
        layer.start_req = 1'b0;
        layer.three_hits = 1'b0;
        layer.hit_a_x = 0; layer.hit_a_y = 0; layer.hit_a_z = 0;
        layer.hit_b_x = 0; layer.hit_b_y = 0; layer.hit_b_z = 0;
        layer.hit_c_x = 0; layer.hit_c_y = 0; layer.hit_c_z = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_backpressure();
        test_tracks();
        send_random(740, 5);
        src_idle_on = 1'b0;
        snk_idle_on = 1'b0;
        send_random(200, 5);
        drain();
        if (n_mismatch == 0 && expected_assignments.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end
endmodule
